// File: hw/rtl/bcg_pkg.sv
// Shared types, constants and register indexes for the corner gradient generator.
package bcg_pkg;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 24;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CHANNELS   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_out_t;

    typedef struct packed {
        logic [RGB_W-1:0] top_left;
        logic [RGB_W-1:0] top_right;
        logic [RGB_W-1:0] bottom_left;
        logic [RGB_W-1:0] bottom_right;
    } corners_t;

endpackage

// File: hw/rtl/bcg_cfg.sv
// Configuration registers: corner colors and the last column and row index.
module bcg_cfg #(
    parameter int MAX_WIDTH  = bcg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bcg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bcg_pkg::corners_t                  corners,
    output logic [$clog2(MAX_WIDTH)-1:0]       last_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]      last_row
);
    import bcg_pkg::*;

    localparam int LW_W = $clog2(MAX_WIDTH);
    localparam int LH_W = $clog2(MAX_HEIGHT);

    corners_t              corners_reg, corners_next;
    logic [LW_W-1:0]       last_col_reg, last_col_next;
    logic [LH_W-1:0]       last_row_reg, last_row_next;

    function automatic logic [31:0] last_of(input logic [SIZE_W-1:0] size, input int max_size);
        logic [31:0] s;
        s = 32'(size);
        if (s < 32'd2)
        begin
            s = 32'd2;
        end
        if (s > 32'(max_size))
        begin
            s = 32'(max_size);
        end
        return s - 32'd1;
    endfunction

    always_comb
    begin
        corners_next  = corners_reg;
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TOP_LEFT:     corners_next.top_left     = cfg_data[RGB_W-1:0];
                REG_TOP_RIGHT:    corners_next.top_right    = cfg_data[RGB_W-1:0];
                REG_BOTTOM_LEFT:  corners_next.bottom_left  = cfg_data[RGB_W-1:0];
                REG_BOTTOM_RIGHT: corners_next.bottom_right = cfg_data[RGB_W-1:0];
                REG_IMAGE_WIDTH:
                    last_col_next = LW_W'(last_of(cfg_data[SIZE_W-1:0], MAX_WIDTH));
                REG_IMAGE_HEIGHT:
                    last_row_next = LH_W'(last_of(cfg_data[SIZE_W-1:0], MAX_HEIGHT));
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corners_reg  <= '0;
            last_col_reg <= LW_W'(1);
            last_row_reg <= LH_W'(1);
        end
        else
        begin
            corners_reg  <= corners_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    assign corners  = corners_reg;
    assign last_col = last_col_reg;
    assign last_row = last_row_reg;

endmodule

// File: hw/rtl/bcg_div.sv
// Pipelined weight divider: clamps a coordinate and forms coord * 2^F / last, one bit a stage.
module bcg_div #(
    parameter int MAX_SIZE      = bcg_pkg::DEF_MAX_WIDTH,
    parameter int FRACTION_BITS = bcg_pkg::DEF_FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [bcg_pkg::COORD_W-1:0]       coord,
    input  logic [$clog2(MAX_SIZE)-1:0]       last,
    output logic                              out_valid,
    output logic [FRACTION_BITS:0]            weight
);
    import bcg_pkg::*;

    localparam int LAST_W = $clog2(MAX_SIZE);
    localparam int RW     = LAST_W + 1;
    localparam int STEPS  = FRACTION_BITS + 1;

    logic [RW-1:0]            rem_reg [0:STEPS];
    logic [FRACTION_BITS:0]   q_reg   [1:STEPS];
    logic                     vld_reg [0:STEPS];
    logic [RW-1:0]            clamp_next;

    always_comb
    begin
        if (32'(coord) > 32'(last))
        begin
            clamp_next = {1'b0, last};
        end
        else
        begin
            clamp_next = RW'(coord);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= clamp_next;
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        logic [RW-1:0]          trial;
        logic                   ge;
        logic [RW-1:0]          rem_next;
        logic [FRACTION_BITS:0] q_next;

        if (k == 1)
        begin : g_first
            assign trial  = rem_reg[0];
            assign q_next = {{FRACTION_BITS{1'b0}}, ge};
        end
        else
        begin : g_rest
            assign trial  = {rem_reg[k-1][RW-2:0], 1'b0};
            assign q_next = {q_reg[k-1][FRACTION_BITS-1:0], ge};
        end

        assign ge       = trial >= {1'b0, last};
        assign rem_next = ge ? trial - {1'b0, last} : trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            q_reg[k]   <= q_next;
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign weight    = q_reg[STEPS];

    a_weight_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= {1'b1, {FRACTION_BITS{1'b0}}})
        else $error("weight above one");

    a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rem_reg[STEPS] < {1'b0, last})
        else $error("division remainder not below the divisor");

endmodule

// File: hw/rtl/bcg_blend.sv
// Two blend stages: horizontal blend along the top and bottom rows, then vertical blend.
module bcg_blend #(
    parameter int FRACTION_BITS = bcg_pkg::DEF_FRACTION_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [FRACTION_BITS:0]  tx,
    input  logic [FRACTION_BITS:0]  ty,
    input  bcg_pkg::corners_t       corners,
    output logic                    done,
    output bcg_pkg::pixel_out_t     color
);
    import bcg_pkg::*;

    localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [CHAN_W-1:0]       top_reg [CHANNELS];
    logic [CHAN_W-1:0]       bot_reg [CHANNELS];
    logic [CHAN_W-1:0]       top_next [CHANNELS];
    logic [CHAN_W-1:0]       bot_next [CHANNELS];
    logic [CHAN_W-1:0]       pix_next [CHANNELS];
    logic [FRACTION_BITS:0]  ty_reg;
    logic                    vld_reg;
    logic                    done_reg;
    pixel_out_t              color_reg, color_next;

    function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b,
                                                input logic [FRACTION_BITS:0] t);
        logic [FRACTION_BITS:0]  tc;
        logic [FRACTION_BITS+8:0] pa;
        logic [FRACTION_BITS+8:0] pb;
        logic [FRACTION_BITS+9:0] s;
        tc = ONE - t;
        pa = (FRACTION_BITS+9)'(tc) * (FRACTION_BITS+9)'(a);
        pb = (FRACTION_BITS+9)'(t) * (FRACTION_BITS+9)'(b);
        s  = (FRACTION_BITS+10)'(pa) + (FRACTION_BITS+10)'(pb);
        return s[FRACTION_BITS+CHAN_W-1:FRACTION_BITS];
    endfunction

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            top_next[k] = blend(corners.top_left[(CHANNELS-1-k)*CHAN_W +: CHAN_W],
                                corners.top_right[(CHANNELS-1-k)*CHAN_W +: CHAN_W], tx);
            bot_next[k] = blend(corners.bottom_left[(CHANNELS-1-k)*CHAN_W +: CHAN_W],
                                corners.bottom_right[(CHANNELS-1-k)*CHAN_W +: CHAN_W], tx);
            pix_next[k] = blend(top_reg[k], bot_reg[k], ty_reg);
        end
        color_next.red   = pix_next[0];
        color_next.green = pix_next[1];
        color_next.blue  = pix_next[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= in_valid;
            done_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            top_reg[k] <= top_next[k];
            bot_reg[k] <= bot_next[k];
        end
        ty_reg    <= ty;
        color_reg <= color_next;
    end

    assign done  = done_reg;
    assign color = color_reg;

endmodule

// File: hw/rtl/bilinear_corner_gradient.sv
// Top level of the four-corner bilinear RGB gradient pixel generator.
//
//  channel   signals                          direction  transfer
//  command   start, busy, coord               in         start high and busy low
//  result    done, color                      out        done high for one cycle
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we high
//
// One item is taken in every cycle that start is high; busy is always low.
// Between an item and its result lie one clamp stage, one divider stage per weight bit,
// and two blend stages.
// Reset clears the valid bits of every stage and sets colors to 0 and both sizes to 2.
// The pipeline never stalls; the receiver must take each result as it appears (not enforced here).
module bilinear_corner_gradient #(
    parameter int MAX_WIDTH     = bcg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bcg_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = bcg_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bcg_pkg::pixel_in_t                 coord,
    output logic                               done,
    output bcg_pkg::pixel_out_t                color,
    input  logic                               cfg_we,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bcg_pkg::*;

    localparam int LATENCY = FRACTION_BITS + 4;

    corners_t                        corners;
    logic [$clog2(MAX_WIDTH)-1:0]    last_col;
    logic [$clog2(MAX_HEIGHT)-1:0]   last_row;
    logic                            accept;
    logic                            tx_valid;
    logic                            ty_valid;
    logic [FRACTION_BITS:0]          tx;
    logic [FRACTION_BITS:0]          ty;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    bcg_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .corners   (corners),
        .last_col  (last_col),
        .last_row  (last_row)
    );

    bcg_div #(
        .MAX_SIZE      (MAX_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .coord     (coord.column),
        .last      (last_col),
        .out_valid (tx_valid),
        .weight    (tx)
    );

    bcg_div #(
        .MAX_SIZE      (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .coord     (coord.row),
        .last      (last_row),
        .out_valid (ty_valid),
        .weight    (ty)
    );

    bcg_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tx_valid),
        .tx       (tx),
        .ty       (ty),
        .corners  (corners),
        .done     (done),
        .color    (color)
    );

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("item taken without a result at the expected cycle");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching item");

    a_weights_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid == ty_valid)
        else $error("horizontal and vertical weights out of step");

endmodule

// File: test/tb_bilinear_corner_gradient.sv
// Self-checking testbench for the four-corner bilinear RGB gradient pixel generator.
`timescale 1ns / 100ps

module tb_bilinear_corner_gradient;
    import bcg_pkg::*;

    localparam int FRAC    = DEF_FRACTION_BITS;
    localparam int LATENCY = FRAC + 4;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    pixel_in_t             coord     = '0;
    logic                  done;
    pixel_out_t            color;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_TOP_LEFT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pixel_in_t  pending_coords[$];
    pixel_out_t expected_colors[$];
    int         sender_idle_pct = 0;
    int         mismatch_count  = 0;

    logic [RGB_W-1:0]  tl_rgb     = '0;
    logic [RGB_W-1:0]  tr_rgb     = '0;
    logic [RGB_W-1:0]  bl_rgb     = '0;
    logic [RGB_W-1:0]  br_rgb     = '0;
    logic [SIZE_W-1:0] width_reg  = 13'd2;
    logic [SIZE_W-1:0] height_reg = 13'd2;

    bilinear_corner_gradient u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .coord     (coord),
        .done      (done),
        .color     (color),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned last_index(logic [SIZE_W-1:0] size, int max_size);
        longint unsigned span;
        span = size;
        if (span < 2)
        begin
            span = 2;
        end
        if (span > max_size)
        begin
            span = max_size;
        end
        return span - 1;
    endfunction

    function automatic longint unsigned pos_weight(logic [COORD_W-1:0] pos,
                                                   logic [SIZE_W-1:0] size, int max_size);
        longint unsigned span;
        longint unsigned p;
        span = last_index(size, max_size);
        p = pos;
        if (p > span)
        begin
            p = span;
        end
        return (p << FRAC) / span;
    endfunction

    function automatic logic [CHAN_W-1:0] lerp8(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                                longint unsigned t);
        logic [63:0] one;
        logic [63:0] acc;
        one = 64'd1 << FRAC;
        acc = (one - t) * a + t * b;
        return CHAN_W'(acc >> FRAC);
    endfunction

    function automatic pixel_out_t predict_color(pixel_in_t c);
        longint unsigned   tx;
        longint unsigned   ty;
        logic [CHAN_W-1:0] top_v;
        logic [CHAN_W-1:0] bot_v;
        logic [CHAN_W-1:0] ch [CHANNELS];
        pixel_out_t        r;
        int                sh;
        tx = pos_weight(c.column, width_reg, DEF_MAX_WIDTH);
        ty = pos_weight(c.row, height_reg, DEF_MAX_HEIGHT);
        for (int k = 0; k < CHANNELS; k++)
        begin
            sh = 16 - 8 * k;
            top_v = lerp8(tl_rgb[sh +: CHAN_W], tr_rgb[sh +: CHAN_W], tx);
            bot_v = lerp8(bl_rgb[sh +: CHAN_W], br_rgb[sh +: CHAN_W], tx);
            ch[k] = lerp8(top_v, bot_v, ty);
        end
        r.red   = ch[0];
        r.green = ch[1];
        r.blue  = ch[2];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_colors.push_back(predict_color(coord));
        end
        if (start && busy)
        begin
            start <= 1'b1;
        end
        else if (rst_n && pending_coords.size() != 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct)
        begin
            start <= 1'b1;
            coord <= pending_coords.pop_front();
        end
        else
        begin
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : color_check
        pixel_out_t want;
        if (rst_n && done)
        begin
            if (expected_colors.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Unexpected result: r=%0d g=%0d b=%0d",
                             color.red, color.green, color.blue);
                end
            end
            else
            begin
                want = expected_colors.pop_front();
                if (color.red !== want.red || color.green !== want.green ||
                    color.blue !== want.blue)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 color.red, color.green, color.blue);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_TOP_LEFT:     tl_rgb = data[RGB_W-1:0];
            REG_TOP_RIGHT:    tr_rgb = data[RGB_W-1:0];
            REG_BOTTOM_LEFT:  bl_rgb = data[RGB_W-1:0];
            REG_BOTTOM_RIGHT: br_rgb = data[RGB_W-1:0];
            REG_IMAGE_WIDTH:  width_reg = data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = data[SIZE_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic write_setup(logic [RGB_W-1:0] tl, logic [RGB_W-1:0] tr,
                               logic [RGB_W-1:0] bl, logic [RGB_W-1:0] br,
                               logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        write_reg(REG_TOP_LEFT, tl);
        write_reg(REG_TOP_RIGHT, tr);
        write_reg(REG_BOTTOM_LEFT, bl);
        write_reg(REG_BOTTOM_RIGHT, br);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_coords.size() != 0 || start || expected_colors.size() != 0);
    endtask

    task automatic push_item(int col, int row);
        pixel_in_t c;
        c.column = col[COORD_W-1:0];
        c.row    = row[COORD_W-1:0];
        pending_coords.push_back(c);
    endtask

    function automatic logic [RGB_W-1:0] pick_rgb();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return RGB_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size_word();
        logic [CFG_DATA_W-1:0] d;
        logic [SIZE_W-1:0]     sz;
        case ($urandom_range(0, 9))
            0:       sz = SIZE_W'($urandom_range(0, 3));
            1:       sz = SIZE_W'(4095 + $urandom_range(0, 2));
            2:       sz = SIZE_W'($urandom);
            3, 4:    sz = SIZE_W'($urandom_range(2, 16));
            default: sz = SIZE_W'($urandom_range(2, 4096));
        endcase
        d = CFG_DATA_W'($urandom);
        d[SIZE_W-1:0] = sz;
        return d;
    endfunction

    function automatic int pick_pos(logic [SIZE_W-1:0] size, int max_size);
        int last;
        last = int'(last_index(size, max_size));
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return last;
            2:       return (last < 4095) ? last + 1 : last;
            3, 4:    return $urandom_range(0, 4095);
            5:       return 4095;
            default: return $urandom_range(0, last);
        endcase
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: black corners on a two by two image.
        push_item(0, 0);
        push_item(4095, 4095);
        push_item(1, 0);
        wait_drained();

        // Largest image, each corner at a channel extreme.
        write_setup(24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h001000, 24'h001000);
        push_item(0, 0);
        push_item(4095, 0);
        push_item(0, 4095);
        push_item(4095, 4095);
        push_item(2048, 2048);
        push_item(1, 4094);
        wait_drained();

        // Sizes below two, and writes to indexes with no register behind them.
        write_setup(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFFE001, 24'h000000);
        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'h123456);
        cfg_we <= 1'b0;
        push_item(0, 0);
        push_item(1, 0);
        push_item(4095, 1);
        push_item(0, 4095);
        wait_drained();

        // Width above the maximum, three rows, coordinates past the edge.
        write_setup(24'hA5A5A5, 24'h5A5A5A, 24'h3C3C3C, 24'hC3C3C3, 24'h001FFF, 24'h000003);
        push_item(4095, 1);
        push_item(4095, 2);
        push_item(2047, 4095);
        push_item(0, 1);
        wait_drained();

        write_setup(24'h123456, 24'hFEDCBA, 24'h0F0F0F, 24'hF0F0F0, 24'hABCFFF, 24'h5A0FFF);
        push_item(4094, 4094);
        push_item(4095, 4093);
        push_item(4093, 0);
        wait_drained();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 3)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 46;
                default: sender_idle_pct = 22;
            endcase
            write_setup(pick_rgb(), pick_rgb(), pick_rgb(), pick_rgb(),
                        pick_size_word(), pick_size_word());
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                          CFG_DATA_W'($urandom));
                cfg_we <= 1'b0;
            end
            for (int half = 0; half < 2; half++)
            begin
                for (int n = 0; n < 65; n++)
                begin
                    push_item(pick_pos(width_reg, DEF_MAX_WIDTH),
                              pick_pos(height_reg, DEF_MAX_HEIGHT));
                end
                wait_drained();
            end
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && expected_colors.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
